>>> rtl/celu_pkg.sv
package celu_pkg;

    // Store sizes
    localparam int MAX_ROWS    = 1024;
    localparam int MAX_ENTRIES = 16384;
    localparam int INDEX_WIDTH = 20;

    // Field and store widths
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 14;
    localparam int VALUE_W  = 20;
    localparam int OFFSET_W = 14;
    localparam int START_W  = 15;
    localparam int COUNT_W  = 11;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int START_AW = $clog2(MAX_ROWS + 1);
    localparam int COL_AW   = $clog2(MAX_ENTRIES);
    localparam int PTR_W    = START_W;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ROW_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROW_NUMBER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COLUMN     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP     = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ROWS_STORED     = 1'b0;
    localparam logic CFG_ROWS_SUCCESSIVE = 1'b1;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [COUNT_W-1:0] rows_stored;
        logic               rows_successive;
    } t_cfg;

    // Store write request
    typedef struct packed {
        logic                row_start_we;
        logic                row_number_we;
        logic                column_we;
        logic [SLOT_W-1:0]   addr;
        logic [VALUE_W-1:0]  data;
    } t_wr_req;

    // Store read addresses
    typedef struct packed {
        logic [START_AW-1:0] row_start_addr;
        logic [ROW_AW-1:0]   row_number_addr;
        logic [COL_AW-1:0]   column_addr;
    } t_rd_req;

endpackage

>>> rtl/celu_ram.sv
module celu_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/celu_seq.sv
module celu_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  celu_pkg::t_cfg                    i_cfg,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [celu_pkg::MODE_W-1:0]       i_mode,
    input  logic [celu_pkg::SLOT_W-1:0]       i_slot,
    input  logic [celu_pkg::VALUE_W-1:0]      i_value,
    input  logic [celu_pkg::INDEX_WIDTH-1:0]  i_query_row,
    input  logic [celu_pkg::INDEX_WIDTH-1:0]  i_query_column,
    // store access
    output celu_pkg::t_wr_req                 o_wr,
    output celu_pkg::t_rd_req                 o_rd,
    input  logic [celu_pkg::START_W-1:0]      i_row_start_q,
    input  logic [celu_pkg::INDEX_WIDTH-1:0]  i_row_number_q,
    input  logic [celu_pkg::INDEX_WIDTH-1:0]  i_column_q,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_found,
    output logic                              o_row_missing,
    output logic [celu_pkg::OFFSET_W-1:0]     o_entry_offset
);
    import celu_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RN_RD   = 4'd1;
    localparam logic [3:0] S_RN_CMP  = 4'd2;
    localparam logic [3:0] S_RS_RD0  = 4'd3;
    localparam logic [3:0] S_RS_RD1  = 4'd4;
    localparam logic [3:0] S_RS_CAP  = 4'd5;
    localparam logic [3:0] S_COL_RD  = 4'd6;
    localparam logic [3:0] S_COL_CMP = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    localparam logic [COUNT_W-1:0] ROWS_LIMIT = COUNT_W'(MAX_ROWS);
    localparam logic [PTR_W-1:0]   END_LIMIT  = PTR_W'(MAX_ENTRIES);
    localparam logic [SLOT_W:0]    RS_SLOTS   = (SLOT_W+1)'(MAX_ROWS + 1);
    localparam logic [SLOT_W:0]    RN_SLOTS   = (SLOT_W+1)'(MAX_ROWS);
    localparam logic [SLOT_W:0]    COL_SLOTS  = (SLOT_W+1)'(MAX_ENTRIES);

    logic [3:0]             r_state, n_state;
    logic [PTR_W-1:0]       r_ptr, n_ptr;
    logic [ROW_AW-1:0]      r_idx, n_idx;
    logic [INDEX_WIDTH-1:0] r_row, n_row;
    logic [INDEX_WIDTH-1:0] r_col, n_col;
    logic [PTR_W-1:0]       r_start, n_start;
    logic [PTR_W-1:0]       r_end, n_end;
    logic [COUNT_W-1:0]     r_n, n_n;
    logic                   r_res_found, n_res_found;
    logic                   r_res_missing, n_res_missing;
    logic [OFFSET_W-1:0]    r_res_off, n_res_off;
    logic                   r_out_valid, n_out_valid;
    logic                   r_found, n_found;
    logic                   r_missing, n_missing;
    logic [OFFSET_W-1:0]    r_off, n_off;

    logic                   accept;
    logic                   cmp_eq;
    logic [PTR_W-1:0]       ptr_inc;
    logic [PTR_W-1:0]       end_clamped;
    logic [COUNT_W-1:0]     rows_n;
    logic                   out_load;
    logic [SLOT_W:0]        slot_ext;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Shared compare unit: row numbers in the row search, columns in the scan
    assign cmp_eq  = (r_state == S_RN_CMP) ? (i_row_number_q == r_row)
                                           : (i_column_q == r_col);
    assign ptr_inc = r_ptr + PTR_W'(1);

    assign end_clamped = (i_row_start_q > END_LIMIT) ? END_LIMIT : i_row_start_q;
    assign rows_n      = (i_cfg.rows_stored > ROWS_LIMIT) ? ROWS_LIMIT
                                                          : i_cfg.rows_stored;

    // Store writes come straight from an accepted write request
    assign slot_ext             = {1'b0, i_slot};
    assign o_wr.row_start_we    = accept && (i_mode == MODE_ROW_START)  && (slot_ext < RS_SLOTS);
    assign o_wr.row_number_we   = accept && (i_mode == MODE_ROW_NUMBER) && (slot_ext < RN_SLOTS);
    assign o_wr.column_we       = accept && (i_mode == MODE_COLUMN)     && (slot_ext < COL_SLOTS);
    assign o_wr.addr            = i_slot;
    assign o_wr.data            = i_value;

    // Read addresses; the start store gives slot then slot+1
    assign o_rd.row_start_addr  = (r_state == S_RS_RD1) ? ({1'b0, r_idx} + START_AW'(1))
                                                        : {1'b0, r_idx};
    assign o_rd.row_number_addr = r_ptr[ROW_AW-1:0];
    assign o_rd.column_addr     = r_ptr[COL_AW-1:0];

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_ptr         = r_ptr;
        n_idx         = r_idx;
        n_row         = r_row;
        n_col         = r_col;
        n_start       = r_start;
        n_end         = r_end;
        n_n           = r_n;
        n_res_found   = r_res_found;
        n_res_missing = r_res_missing;
        n_res_off     = r_res_off;
        out_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_mode == MODE_LOOKUP)) begin
                    n_row         = i_query_row;
                    n_col         = i_query_column;
                    n_n           = rows_n;
                    n_ptr         = '0;
                    n_res_found   = 1'b0;
                    n_res_missing = 1'b0;
                    n_res_off     = '0;
                    if (i_cfg.rows_successive) begin
                        if (i_query_row < {{(INDEX_WIDTH-COUNT_W){1'b0}}, rows_n}) begin
                            n_idx   = i_query_row[ROW_AW-1:0];
                            n_state = S_RS_RD0;
                        end else begin
                            n_res_missing = 1'b1;
                            n_state       = S_DONE;
                        end
                    end else if (rows_n == '0) begin
                        n_res_missing = 1'b1;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_RN_RD;
                    end
                end
            end
            S_RN_RD: begin
                n_state = S_RN_CMP;
            end
            S_RN_CMP: begin
                if (cmp_eq) begin
                    n_idx   = r_ptr[ROW_AW-1:0];
                    n_state = S_RS_RD0;
                end else if (ptr_inc == {{(PTR_W-COUNT_W){1'b0}}, r_n}) begin
                    n_res_missing = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_ptr   = ptr_inc;
                    n_state = S_RN_RD;
                end
            end
            S_RS_RD0: begin
                n_state = S_RS_RD1;
            end
            S_RS_RD1: begin
                // data of the row's own slot arrives here
                n_start = i_row_start_q;
                n_state = S_RS_CAP;
            end
            S_RS_CAP: begin
                n_end = end_clamped;
                n_ptr = r_start;
                if (r_start >= end_clamped) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_COL_RD;
                end
            end
            S_COL_RD: begin
                n_state = S_COL_CMP;
            end
            S_COL_CMP: begin
                if (cmp_eq) begin
                    n_res_found = 1'b1;
                    n_res_off   = r_ptr[OFFSET_W-1:0];
                    n_state     = S_DONE;
                end else if (ptr_inc >= r_end) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr   = ptr_inc;
                    n_state = S_COL_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_found     = r_found;
        n_missing   = r_missing;
        n_off       = r_off;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_found     = r_res_found;
            n_missing   = r_res_missing;
            n_off       = r_res_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_idx         <= n_idx;
        r_row         <= n_row;
        r_col         <= n_col;
        r_start       <= n_start;
        r_end         <= n_end;
        r_n           <= n_n;
        r_res_found   <= n_res_found;
        r_res_missing <= n_res_missing;
        r_res_off     <= n_res_off;
        r_found       <= n_found;
        r_missing     <= n_missing;
        r_off         <= n_off;
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_row_missing  = r_missing;
    assign o_entry_offset = r_off;

    // Checks
    a_found_xor_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_found && r_missing))
        else $error("found and row_missing both set");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_off == '0))
        else $error("nonzero offset on a miss");

    a_scan_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL_CMP) |-> (r_ptr < r_end))
        else $error("column scan past row end");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RN_CMP) |-> (r_ptr < {{(PTR_W-COUNT_W){1'b0}}, r_n}))
        else $error("row search past stored rows");

    a_lookup_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == MODE_LOOKUP)) |=> o_in_stall)
        else $error("lookup accepted without stalling");

endmodule

>>> rtl/csr_entry_lookup_core.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------------------
// request   | in        | i_in_valid / o_in_stall    | i_mode i_slot i_value i_query_row/column
// result    | out       | o_out_valid / i_out_stall  | o_found o_row_missing o_entry_offset
// config    | in        | i_cfg_we                   | i_cfg_index i_cfg_data
//
// Write requests give no result. A lookup compares R row numbers one read at a time
// (R = 0 with successive rows), reads the row's start offsets, then compares C columns
// one read at a time, all through one comparator, before its result is registered; a
// missing row skips the offset reads and the scan.
// Reset clears the sequencer, output valid and the configuration registers; stores need writes before use.
// A result waiting under stall holds the sequencer in its final step.
module csr_entry_lookup_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [celu_pkg::COUNT_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [celu_pkg::MODE_W-1:0]       i_mode,
    input  logic [celu_pkg::SLOT_W-1:0]       i_slot,
    input  logic [celu_pkg::VALUE_W-1:0]      i_value,
    input  logic [celu_pkg::INDEX_WIDTH-1:0]  i_query_row,
    input  logic [celu_pkg::INDEX_WIDTH-1:0]  i_query_column,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_found,
    output logic                              o_row_missing,
    output logic [celu_pkg::OFFSET_W-1:0]     o_entry_offset
);
    import celu_pkg::*;

    logic [COUNT_W-1:0]     r_rows_stored;
    logic                   r_rows_successive;
    t_cfg                   cfg;
    t_wr_req                wr;
    t_rd_req                rd;
    logic [START_W-1:0]     row_start_q;
    logic [INDEX_WIDTH-1:0] row_number_q;
    logic [INDEX_WIDTH-1:0] column_q;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_stored     <= '0;
            r_rows_successive <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS_STORED:     r_rows_stored     <= i_cfg_data;
                CFG_ROWS_SUCCESSIVE: r_rows_successive <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.rows_stored     = r_rows_stored;
    assign cfg.rows_successive = r_rows_successive;

    // Row start offsets
    celu_ram #(
        .DEPTH(MAX_ROWS + 1),
        .WIDTH(START_W)
    ) u_row_start (
        .i_clk  (i_clk),
        .i_we   (wr.row_start_we),
        .i_waddr(wr.addr[START_AW-1:0]),
        .i_wdata(wr.data[START_W-1:0]),
        .i_raddr(rd.row_start_addr),
        .o_rdata(row_start_q)
    );

    // Stored row numbers
    celu_ram #(
        .DEPTH(MAX_ROWS),
        .WIDTH(INDEX_WIDTH)
    ) u_row_number (
        .i_clk  (i_clk),
        .i_we   (wr.row_number_we),
        .i_waddr(wr.addr[ROW_AW-1:0]),
        .i_wdata(wr.data[INDEX_WIDTH-1:0]),
        .i_raddr(rd.row_number_addr),
        .o_rdata(row_number_q)
    );

    // Entry columns
    celu_ram #(
        .DEPTH(MAX_ENTRIES),
        .WIDTH(INDEX_WIDTH)
    ) u_column (
        .i_clk  (i_clk),
        .i_we   (wr.column_we),
        .i_waddr(wr.addr[COL_AW-1:0]),
        .i_wdata(wr.data[INDEX_WIDTH-1:0]),
        .i_raddr(rd.column_addr),
        .o_rdata(column_q)
    );

    // Lookup sequencer and result register
    celu_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_slot        (i_slot),
        .i_value       (i_value),
        .i_query_row   (i_query_row),
        .i_query_column(i_query_column),
        .o_wr          (wr),
        .o_rd          (rd),
        .i_row_start_q (row_start_q),
        .i_row_number_q(row_number_q),
        .i_column_q    (column_q),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_row_missing (o_row_missing),
        .o_entry_offset(o_entry_offset)
    );

endmodule

>>> dv/tb_csr_entry_lookup_core.sv
module tb_csr_entry_lookup_core;
    import celu_pkg::*;

    localparam int FULL_INDEX    = (1 << INDEX_WIDTH) - 1;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic                found;
        logic                row_missing;
        logic [OFFSET_W-1:0] entry_offset;
    } lookup_result_t;

    // Shadow of the three stores plus the lookup results still owed by the block
    class entry_ledger;
        logic [START_W-1:0]     row_start  [MAX_ROWS+1];
        logic [INDEX_WIDTH-1:0] row_number [MAX_ROWS];
        logic [INDEX_WIDTH-1:0] column     [MAX_ENTRIES];
        bit                     start_set  [MAX_ROWS+1];
        bit                     number_set [MAX_ROWS];
        bit                     column_set [MAX_ENTRIES];
        int unsigned            rows_stored = 0;
        bit                     rows_successive = 1;
        lookup_result_t         pending[$];
        int failures = 0;
        int lookups  = 0;
        int hits     = 0;
        int misses   = 0;
        int writes   = 0;
        int settings = 0;

        function int row_count();
            return (rows_stored > MAX_ROWS) ? MAX_ROWS : rows_stored;
        endfunction

        function void set_register(logic index, logic [COUNT_W-1:0] data);
            if (index == CFG_ROWS_STORED) begin
                rows_stored = data;
            end else begin
                rows_successive = data[0];
            end
            settings++;
        endfunction

        // Expected lookup outcome; returns 0 if the walk would read an unwritten entry
        function bit locate_entry(input logic [INDEX_WIDTH-1:0] row, col,
                                  output lookup_result_t res);
            int n;
            int slot_idx;
            int lo_off;
            int hi_off;
            bit have;
            n = row_count();
            slot_idx = 0;
            have = 0;
            res = '0;
            if (rows_successive) begin
                if (row < n) begin
                    slot_idx = row;
                    have = 1;
                end
            end else begin
                for (int p = 0; p < n && !have; p++) begin
                    if (!number_set[p]) return 0;
                    if (row_number[p] == row) begin
                        slot_idx = p;
                        have = 1;
                    end
                end
            end
            if (!have) begin
                res.row_missing = 1'b1;
                return 1;
            end
            if (!start_set[slot_idx] || !start_set[slot_idx+1]) return 0;
            lo_off = row_start[slot_idx];
            hi_off = row_start[slot_idx+1];
            if (hi_off > MAX_ENTRIES) hi_off = MAX_ENTRIES;
            // lowest matching offset wins; empty or reversed rows fall through
            for (int p = lo_off; p < hi_off; p++) begin
                if (!column_set[p]) return 0;
                if (column[p] == col) begin
                    res.found = 1'b1;
                    res.entry_offset = p[OFFSET_W-1:0];
                    return 1;
                end
            end
            return 1;
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                                   logic [VALUE_W-1:0] value,
                                   logic [INDEX_WIDTH-1:0] row, col);
            lookup_result_t res;
            case (mode)
                MODE_ROW_START: begin
                    writes++;
                    if (slot <= MAX_ROWS) begin
                        row_start[slot] = value[START_W-1:0];
                        start_set[slot] = 1;
                    end
                end
                MODE_ROW_NUMBER: begin
                    writes++;
                    if (slot < MAX_ROWS) begin
                        row_number[slot] = value;
                        number_set[slot] = 1;
                    end
                end
                MODE_COLUMN: begin
                    writes++;
                    column[slot] = value;
                    column_set[slot] = 1;
                end
                default: begin
                    void'(locate_entry(row, col, res));
                    pending.push_back(res);
                    lookups++;
                    hits += res.found;
                    misses += res.row_missing;
                end
            endcase
        endfunction

        function void check_result(logic found, logic row_missing,
                                   logic [OFFSET_W-1:0] entry_offset);
            lookup_result_t want;
            if (pending.size() == 0) begin
                $error("result with no lookup outstanding: found=%0d row_missing=%0d offset=%0d",
                       found, row_missing, entry_offset);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, found);
                failures++;
            end
            if (row_missing !== want.row_missing) begin
                $error("row_missing: expected %0d, actual %0d", want.row_missing, row_missing);
                failures++;
            end
            if (entry_offset !== want.entry_offset) begin
                $error("entry_offset: expected %0d, actual %0d",
                       want.entry_offset, entry_offset);
                failures++;
            end
        endfunction
    endclass

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic                   i_cfg_index    = 1'b0;
    logic [COUNT_W-1:0]     i_cfg_data     = '0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [MODE_W-1:0]      i_mode         = '0;
    logic [SLOT_W-1:0]      i_slot         = '0;
    logic [VALUE_W-1:0]     i_value        = '0;
    logic [INDEX_WIDTH-1:0] i_query_row    = '0;
    logic [INDEX_WIDTH-1:0] i_query_column = '0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic                   o_found;
    logic                   o_row_missing;
    logic [OFFSET_W-1:0]    o_entry_offset;

    entry_ledger ledger = new();
    int gap_pct   = 0;
    int stall_pct = 0;
    int matrix_lo = 0;
    int matrix_hi = 0;
    int loaded_slots[$];

    csr_entry_lookup_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_slot         (i_slot),
        .i_value        (i_value),
        .i_query_row    (i_query_row),
        .i_query_column (i_query_column),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_row_missing  (o_row_missing),
        .o_entry_offset (o_entry_offset)
    );

    always #10 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            ledger.check_result(o_found, o_row_missing, o_entry_offset);
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                                input logic [VALUE_W-1:0] value,
                                input logic [INDEX_WIDTH-1:0] row, col);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_slot         <= slot;
        i_value        <= value;
        i_query_row    <= row;
        i_query_column <= col;
        do @(posedge i_clk); while (o_in_stall);
        ledger.note_request(mode, slot, value, row, col);
    endtask

    task automatic store_write(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                               input logic [VALUE_W-1:0] value);
        send_request(mode, slot, value, $urandom_range(0, FULL_INDEX),
                     $urandom_range(0, FULL_INDEX));
    endtask

    task automatic send_lookup(input logic [INDEX_WIDTH-1:0] row, col);
        send_request(MODE_LOOKUP, $urandom_range(0, MAX_ENTRIES - 1),
                     $urandom_range(0, FULL_INDEX), row, col);
    endtask

    // Hold off new requests until every outstanding lookup has answered
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.pending.size() != 0);
    endtask

    task automatic write_config(input logic index, input logic [COUNT_W-1:0] data);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        ledger.set_register(index, data);
    endtask

    // Mostly a small column pool so duplicates and near misses are common
    function automatic logic [INDEX_WIDTH-1:0] pick_column();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, FULL_INDEX)
                                           : $urandom_range(0, 15);
    endfunction

    // Well-formed CSR table; wide tables carry columns only in the first and last rows
    task automatic load_matrix(input int n_rows, input bit successive);
        int pos;
        int num;
        int len;
        int flip;
        bit keep_here;
        bit keep_next;
        pos = $urandom_range(0, MAX_ENTRIES - 200);
        matrix_lo = pos;
        loaded_slots.delete();
        for (int p = 0; p <= n_rows; p++) begin
            keep_here = (p <= 8) || (p >= n_rows - 8);
            keep_next = (p + 1 <= 8) || (p + 1 >= n_rows - 8);
            if (p < n_rows && !successive) begin
                if (n_rows > 16) begin
                    num = (p * 977 + matrix_lo) % (FULL_INDEX + 1);
                end else if (p > 0 && $urandom_range(0, 3) == 0) begin
                    num = ledger.row_number[$urandom_range(0, p - 1)];
                end else begin
                    num = $urandom_range(0, 1) ? $urandom_range(0, FULL_INDEX)
                                               : $urandom_range(0, 31);
                end
                store_write(MODE_ROW_NUMBER, p, num);
            end
            if (keep_here) store_write(MODE_ROW_START, p, pos);
            if (p < n_rows && keep_here && keep_next) begin
                len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                repeat (len) begin
                    store_write(MODE_COLUMN, pos, pick_column());
                    pos++;
                end
                loaded_slots.push_back(p);
            end
        end
        matrix_hi = pos;
        // now and then make one row reversed or empty
        if (n_rows >= 2 && n_rows <= 16 && $urandom_range(0, 2) == 0) begin
            flip = $urandom_range(0, n_rows - 2);
            store_write(MODE_ROW_START, flip + 1,
                        (ledger.row_start[flip] > 0) ? ledger.row_start[flip] - 1 : 0);
        end
    endtask

    // Lookup aimed mostly at stored entries, never walking unwritten store entries
    task automatic random_lookup();
        lookup_result_t res;
        logic [INDEX_WIDTH-1:0] row;
        logic [INDEX_WIDTH-1:0] col;
        int p;
        int lo_off;
        int hi_off;
        int kind;
        bit done;
        done = 0;
        for (int t = 0; t < 8 && !done; t++) begin
            kind = $urandom_range(0, 9);
            row = $urandom_range(0, 40);
            col = pick_column();
            if (kind < 6 && loaded_slots.size() != 0) begin
                p = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
                row = (ledger.rows_successive || !ledger.number_set[p]) ? p
                                                                        : ledger.row_number[p];
                if (ledger.start_set[p] && ledger.start_set[p+1] && $urandom_range(0, 3) != 0) begin
                    lo_off = ledger.row_start[p];
                    hi_off = ledger.row_start[p+1];
                    if (hi_off > MAX_ENTRIES) hi_off = MAX_ENTRIES;
                    if (hi_off > lo_off) begin
                        p = $urandom_range(lo_off, hi_off - 1);
                        if (ledger.column_set[p]) col = ledger.column[p];
                    end
                end
            end else if (kind < 8) begin
                row = (ledger.rows_successive && $urandom_range(0, 1))
                    ? ledger.row_count() + $urandom_range(0, 3)
                    : $urandom_range(0, FULL_INDEX);
            end
            done = ledger.locate_entry(row, col, res);
        end
        if (done) begin
            send_lookup(row, col);
        end else begin
            store_write(MODE_COLUMN, $urandom_range(0, MAX_ENTRIES - 1), pick_column());
        end
    endtask

    // One configuration setting: program, load a table, then mixed traffic
    task automatic run_phase(input bit successive, input int rows_cfg, input int n_load,
                             input int count);
        int pick;
        write_config(CFG_ROWS_SUCCESSIVE, successive);
        write_config(CFG_ROWS_STORED, rows_cfg);
        if (n_load > 0) load_matrix(n_load, successive);
        repeat (count) begin
            if ($urandom_range(0, 39) == 0) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                random_lookup();
            end else if (pick < 88 && matrix_hi > matrix_lo) begin
                store_write(MODE_COLUMN, $urandom_range(matrix_lo, matrix_hi - 1), pick_column());
            end else begin
                // stray writes: out-of-range slots and wide values
                store_write($urandom_range(MODE_ROW_START, MODE_COLUMN),
                            $urandom_range(0, 1) ? $urandom_range(MAX_ROWS - 1, MAX_ENTRIES - 1)
                                                 : $urandom_range(0, 40),
                            $urandom_range(0, FULL_INDEX));
            end
        end
    endtask

    // Run limit
    initial begin
        #40_000_000;
        $display("tb_csr_entry_lookup_core failed");
        $finish;
    end

    initial begin
        gap_pct   = 18;
        stall_pct = 56;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // successive rows: duplicate columns, extreme column value, empty row, missing rows
        write_config(CFG_ROWS_STORED, 2);
        store_write(MODE_ROW_START, 0, 0);
        store_write(MODE_ROW_START, 1, 3);
        store_write(MODE_ROW_START, 2, 3);
        store_write(MODE_COLUMN, 0, FULL_INDEX);
        store_write(MODE_COLUMN, 1, 5);
        store_write(MODE_COLUMN, 2, 5);
        send_lookup(0, 5);
        send_lookup(0, FULL_INDEX);
        send_lookup(1, 5);
        send_lookup(2, 0);
        // wide start value truncates and leaves row 1 reversed
        store_write(MODE_ROW_START, 2, 20'h08001);
        send_lookup(1, 5);
        store_write(MODE_ROW_START, MAX_ROWS + 1, 0);
        store_write(MODE_ROW_NUMBER, MAX_ROWS, FULL_INDEX);

        // searched rows with duplicate row numbers
        write_config(CFG_ROWS_SUCCESSIVE, 0);
        store_write(MODE_ROW_NUMBER, 0, FULL_INDEX);
        store_write(MODE_ROW_NUMBER, 1, FULL_INDEX);
        send_lookup(FULL_INDEX, 5);
        send_lookup(0, 5);

        // row running past the end of the entry store
        write_config(CFG_ROWS_SUCCESSIVE, 1);
        write_config(CFG_ROWS_STORED, 1);
        store_write(MODE_COLUMN, MAX_ENTRIES - 3, 9);
        store_write(MODE_COLUMN, MAX_ENTRIES - 2, 0);
        store_write(MODE_COLUMN, MAX_ENTRIES - 1, 20'hABCDE);
        store_write(MODE_ROW_START, 0, MAX_ENTRIES - 3);
        store_write(MODE_ROW_START, 1, FULL_INDEX);
        send_lookup(0, 20'hABCDE);
        send_lookup(0, 1);

        // row count above the store size acts as the store size
        write_config(CFG_ROWS_STORED, 2047);
        store_write(MODE_ROW_START, MAX_ROWS - 1, MAX_ENTRIES - 2);
        store_write(MODE_ROW_START, MAX_ROWS, MAX_ENTRIES);
        send_lookup(MAX_ROWS - 1, 20'hABCDE);
        send_lookup(MAX_ROWS, 0);

        run_phase(1, 0, 0, 40);
        run_phase(0, 6, 6, 90);
        run_phase(1, 12, 12, 90);

        gap_pct   = 56;
        stall_pct = 18;
        run_phase(0, 1, 1, 90);
        run_phase(1, 16, 16, 90);
        run_phase(0, 0, 0, 40);
        run_phase(0, 10, 10, 90);

        gap_pct   = 0;
        stall_pct = 0;
        run_phase(1, 4, 4, 90);
        run_phase(0, 16, 16, 90);
        run_phase(0, 128, 128, 50);
        run_phase(0, 2047, 0, 30);
        run_phase(1, MAX_ROWS, MAX_ROWS, 40);
        run_phase(1, 2047, 0, 30);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Checked %0d lookups (%0d found, %0d on missing rows) against %0d store writes.",
                 ledger.lookups, ledger.hits, ledger.misses, ledger.writes);
        $display("Used %0d register writes: empty to full row tables, successive and searched.",
                 ledger.settings);
        if (ledger.failures == 0 && ledger.pending.size() == 0) begin
            $display("tb_csr_entry_lookup_core passed");
        end else begin
            $display("tb_csr_entry_lookup_core failed");
        end
        $finish;
    end

endmodule
